>>> hdl/aalw_pkg.sv
// ----------------------------------------------------------------------------
// aalw_pkg
// shared types and constants for the ansi-aware line wrapper
// ----------------------------------------------------------------------------
package aalw_pkg;

	localparam int unsigned LineNumberBitsDefault = 16;
	localparam int unsigned ShownLineBits         = 16;
	localparam logic [7:0]  LineWidthReset        = 8'd80;

	localparam logic [7:0] ByteEsc       = 8'h1B;
	localparam logic [7:0] ByteBel       = 8'h07;
	localparam logic [7:0] ByteNl        = 8'h0A;
	localparam logic [7:0] ByteLBracket  = 8'h5B;
	localparam logic [7:0] ByteRBracket  = 8'h5D;
	localparam logic [7:0] ByteBackslash = 8'h5C;
	localparam logic [7:0] ByteLowerM    = 8'h6D;
	localparam logic [7:0] ByteUpperH    = 8'h48;
	localparam logic [7:0] ByteUpperJ    = 8'h4A;

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_ESC     = 3'd1,
		MODE_CSI     = 3'd2,
		MODE_OSC     = 3'd3,
		MODE_OSC_ESC = 3'd4
	} mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       first_of_text;
	} item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        keeps_byte;
		logic        starts_line;
		logic        is_escape;
		logic [15:0] line_number;
		logic [7:0]  column;
	} result_t;

	// state of an osc string after one content byte
	function automatic mode_t osc_content(input logic [7:0] b);
		mode_t m;
		if (b == ByteBel) begin
			m = MODE_NORMAL;
		end else if (b == ByteEsc) begin
			m = MODE_OSC_ESC;
		end else begin
			m = MODE_OSC;
		end
		return m;
	endfunction

endpackage

>>> hdl/aalw_step.sv
// ----------------------------------------------------------------------------
// aalw_step
// per-byte wrap decision: next escape mode, column and line, plus the result
// ----------------------------------------------------------------------------
module aalw_step #(
	parameter int unsigned LINE_NUMBER_BITS = aalw_pkg::LineNumberBitsDefault
) (
	input  aalw_pkg::item_t             item,
	input  aalw_pkg::mode_t             mode,
	input  logic [7:0]                  count,
	input  logic [LINE_NUMBER_BITS-1:0] line,
	input  logic [7:0]                  width,
	output aalw_pkg::mode_t             mode_next,
	output logic [7:0]                  count_next,
	output logic [LINE_NUMBER_BITS-1:0] line_next,
	output aalw_pkg::result_t           result
);

	aalw_pkg::mode_t             mode_cur;
	logic [7:0]                  count_cur;
	logic [LINE_NUMBER_BITS-1:0] line_cur;
	logic [7:0]                  b;
	logic                        keeps;
	logic                        starts;
	logic                        esc;
	logic [32:0]                 line_wide;

	assign b = item.text_byte;

	// a new text clears the state before the byte is judged
	always_comb begin
		if (item.first_of_text) begin
			mode_cur  = aalw_pkg::MODE_NORMAL;
			count_cur = 8'd0;
			line_cur  = '0;
		end else begin
			mode_cur  = mode;
			count_cur = count;
			line_cur  = line;
		end
	end

	always_comb begin
		mode_next  = mode_cur;
		count_next = count_cur;
		line_next  = line_cur;
		keeps      = 1'b1;
		starts     = 1'b0;
		esc        = 1'b0;
		case (mode_cur)
			aalw_pkg::MODE_ESC: begin
				esc = 1'b1;
				if (b == aalw_pkg::ByteLBracket) begin
					mode_next = aalw_pkg::MODE_CSI;
				end else if (b == aalw_pkg::ByteRBracket) begin
					mode_next = aalw_pkg::MODE_OSC;
				end else begin
					mode_next = aalw_pkg::MODE_NORMAL;
				end
			end
			aalw_pkg::MODE_CSI: begin
				esc = 1'b1;
				if (b == aalw_pkg::ByteLowerM || b == aalw_pkg::ByteUpperH ||
				    b == aalw_pkg::ByteUpperJ) begin
					mode_next = aalw_pkg::MODE_NORMAL;
				end
			end
			aalw_pkg::MODE_OSC: begin
				esc       = 1'b1;
				mode_next = aalw_pkg::osc_content(b);
			end
			aalw_pkg::MODE_OSC_ESC: begin
				esc = 1'b1;
				if (b == aalw_pkg::ByteBackslash) begin
					mode_next = aalw_pkg::MODE_NORMAL;
				end else begin
					mode_next = aalw_pkg::osc_content(b);
				end
			end
			default: begin
				if (b == aalw_pkg::ByteEsc) begin
					esc       = 1'b1;
					mode_next = aalw_pkg::MODE_ESC;
				end else if (b == aalw_pkg::ByteNl || count_cur >= width) begin
					starts    = 1'b1;
					mode_next = mode_cur;
					if (line_cur != {LINE_NUMBER_BITS{1'b1}}) begin
						line_next = line_cur + 1'b1;
					end
					if (b == aalw_pkg::ByteNl) begin
						keeps      = 1'b0;
						count_next = 8'd0;
					end else begin
						count_next = 8'd1;
					end
				end else begin
					mode_next  = aalw_pkg::MODE_NORMAL;
					count_next = count_cur + 8'd1;
				end
			end
		endcase
	end

	// reported line number clamps to the field width
	assign line_wide = 33'(line_next);

	always_comb begin
		result.out_byte    = b;
		result.keeps_byte  = keeps;
		result.starts_line = starts;
		result.is_escape   = esc;
		result.line_number = (line_wide > 33'h0FFFF) ? 16'hFFFF : line_wide[15:0];
		result.column      = count_next;
	end

endmodule

>>> hdl/ansi_aware_line_wrapper.sv
// ----------------------------------------------------------------------------
// ansi_aware_line_wrapper
// reports where each byte of a text lands when wrapped to a visible width
// ----------------------------------------------------------------------------
// Takes one text byte per beat and returns one result beat per byte: the
// byte itself, whether it is kept or is a dropped newline, whether it opens
// a new line, whether it is part of an ansi escape sequence, its line number
// (saturating) and the visible column after it. A byte is held in the
// input register and is judged on the way into the result register, so a
// new byte can be taken every cycle while the result side does not stall;
// escape mode, column and line counters are updated as each byte moves on.
// The result register parts the two sides: a byte is still taken while the
// previous result waits, and the input stalls only when both registers are
// full and the result side stalls. The user writes line_width (reset 80)
// through cfg_wr_en/cfg_wr_data only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module ansi_aware_line_wrapper #(
	parameter int unsigned LINE_NUMBER_BITS = aalw_pkg::LineNumberBitsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_wr_en,
	input  logic [7:0]        cfg_wr_data,
	// input byte channel
	input  logic              item_valid,
	output logic              item_stall,
	input  aalw_pkg::item_t   item,
	// result channel
	output logic              result_valid,
	input  logic              result_stall,
	output aalw_pkg::result_t result
);

	// input register
	logic                        valid_s1;
	aalw_pkg::item_t             item_s1;

	// wrap state
	aalw_pkg::mode_t             mode_q;
	logic [7:0]                  count_q;
	logic [LINE_NUMBER_BITS-1:0] line_q;
	logic [7:0]                  width_q;

	// result register
	logic                        result_valid_q;
	aalw_pkg::result_t           result_q;

	aalw_pkg::mode_t             mode_next;
	logic [7:0]                  count_next;
	logic [LINE_NUMBER_BITS-1:0] line_next;
	aalw_pkg::result_t           result_next;

	logic                        advance;
	logic                        item_take;

	// byte in s1 moves on when the result register is empty or being drained
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign item_take  = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item;
		end
	end

	aalw_step #(
		.LINE_NUMBER_BITS(LINE_NUMBER_BITS)
	) u_step (
		.item      (item_s1),
		.mode      (mode_q),
		.count     (count_q),
		.line      (line_q),
		.width     (width_q),
		.mode_next (mode_next),
		.count_next(count_next),
		.line_next (line_next),
		.result    (result_next)
	);

	// state only moves when a byte is committed to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= aalw_pkg::MODE_NORMAL;
			count_q <= 8'd0;
			line_q  <= '0;
		end else if (advance) begin
			mode_q  <= mode_next;
			count_q <= count_next;
			line_q  <= line_next;
		end
	end

	// line width register; the user writes it only while idle (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= aalw_pkg::LineWidthReset;
		end else if (cfg_wr_en) begin
			width_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
